@@ hw/rtl/chc_pkg.sv @@
// ----------------------------------------------------------------------------
// chc_pkg
// Shared types and constants for the histogram clip contrast stretch block.
// ----------------------------------------------------------------------------
package chc_pkg;

   // Bin and sample geometry
   localparam int BIN_W   = 8;
   localparam int BIN_NUM = 256;

   // Clip threshold is sample_total / CLIP_DIV
   localparam int CLIP_DIV = 1000;

   // Divisor width of the table divider (covers any bound span)
   localparam int DSR_W = BIN_W;

   // Default saturation limit of the sample count
   localparam longint unsigned MAX_SAMPLES_DEFAULT = 64'd16777216;

   // Bounds after reset and for an empty or degenerate histogram
   localparam logic [BIN_W-1:0] LOW_DEFAULT  = 8'd0;
   localparam logic [BIN_W-1:0] HIGH_DEFAULT = 8'd255;

   // Action codes of the request channel
   localparam logic [1:0] ACT_COUNT = 2'd0;
   localparam logic [1:0] ACT_CLOSE = 2'd1;
   localparam logic [1:0] ACT_MAP   = 2'd2;

   // Result kinds
   localparam logic KIND_BOUNDS = 1'b0;
   localparam logic KIND_MAP    = 1'b1;

   // Histogram memory control
   typedef struct packed {
      logic             count_en;
      logic [BIN_W-1:0] bin;
      logic             scan_en;
      logic [BIN_W-1:0] scan_addr;
      logic             clear;
   } hist_ctl_type;

   // Stretch table write port
   typedef struct packed {
      logic             en;
      logic [BIN_W-1:0] addr;
      logic [BIN_W-1:0] data;
   } lut_wr_type;

endpackage

@@ hw/rtl/chc_divider.sv @@
// ----------------------------------------------------------------------------
// chc_divider
// Restoring divider, one quotient bit per cycle, used by the stretch table
// build.
// ----------------------------------------------------------------------------
module chc_divider import chc_pkg::*; #(
   parameter int DIVIDEND_W = 25
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [DIVIDEND_W-1:0] dividend,
   input  logic [DSR_W-1:0]      divisor,
   output logic                  done,
   output logic [DIVIDEND_W-1:0] quotient
);

   localparam int STEP_W = (DIVIDEND_W > 1) ? $clog2(DIVIDEND_W) : 1;
   localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(DIVIDEND_W - 1);

   logic                  busy_ff;
   logic                  done_ff;
   logic [STEP_W-1:0]     step_ff;
   logic [DIVIDEND_W-1:0] quo_ff;
   logic [DSR_W-1:0]      rem_ff;
   logic [DSR_W-1:0]      dsr_ff;

   logic [DSR_W:0]        trial;
   logic [DSR_W:0]        diff;
   logic                  fits;

   // Shift in the next dividend bit and try to subtract
   assign trial = {rem_ff, quo_ff[DIVIDEND_W-1]};
   assign diff  = trial - {1'b0, dsr_ff};
   assign fits  = (trial >= {1'b0, dsr_ff});

   // Control: run for one step per dividend bit, pulse done at the end
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            step_ff <= '0;
         end else if (busy_ff) begin
            step_ff <= step_ff + 1'b1;
            if (step_ff == STEP_LAST) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // Datapath
   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= dividend;
         rem_ff <= '0;
         dsr_ff <= divisor;
      end else if (busy_ff) begin
         rem_ff <= fits ? diff[DSR_W-1:0] : trial[DSR_W-1:0];
         quo_ff <= {quo_ff[DIVIDEND_W-2:0], fits};
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

@@ hw/rtl/chc_hist.sv @@
// ----------------------------------------------------------------------------
// chc_hist
// Histogram bin memory with read-modify-write increment, scan read port and
// per-bin valid bits for clearing.
// ----------------------------------------------------------------------------
module chc_hist import chc_pkg::*; #(
   parameter int CNT_W = 25
) (
   input  logic             clock,
   input  logic             reset,
   input  hist_ctl_type     ctl,
   output logic [CNT_W-1:0] scan_data
);

   logic [CNT_W-1:0]   mem [BIN_NUM];
   logic [BIN_NUM-1:0] valid_ff;

   logic [CNT_W-1:0]   rd_data_ff;
   logic [BIN_W-1:0]   rd_addr_ff;
   logic               inc_ff;
   logic               fwd_valid_ff;
   logic [BIN_W-1:0]   fwd_addr_ff;
   logic [CNT_W-1:0]   fwd_data_ff;

   logic               rd_en;
   logic [BIN_W-1:0]   rd_addr;
   logic [CNT_W-1:0]   stored;
   logic [CNT_W-1:0]   old_count;
   logic [CNT_W-1:0]   new_count;

   // Count reads take the port before scan reads (never both at once)
   assign rd_en   = ctl.count_en | ctl.scan_en;
   assign rd_addr = ctl.count_en ? ctl.bin : ctl.scan_addr;

   // Entries never written since the last clear read as zero
   assign stored    = valid_ff[rd_addr_ff] ? rd_data_ff : '0;
   // Forward the write of the previous cycle, which the read did not see
   assign old_count = (fwd_valid_ff && (fwd_addr_ff == rd_addr_ff)) ? fwd_data_ff : stored;
   assign new_count = old_count + 1'b1;
   assign scan_data = stored;

   // Memory read and write ports
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
         rd_addr_ff <= rd_addr;
      end
      if (inc_ff) begin
         mem[rd_addr_ff] <= new_count;
      end
      fwd_addr_ff <= rd_addr_ff;
      fwd_data_ff <= new_count;
   end

   // Increment pipeline control and valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         inc_ff       <= 1'b0;
         fwd_valid_ff <= 1'b0;
         valid_ff     <= '0;
      end else begin
         inc_ff       <= ctl.count_en;
         fwd_valid_ff <= inc_ff;
         if (inc_ff) begin
            valid_ff[rd_addr_ff] <= 1'b1;
         end
         if (ctl.clear) begin
            valid_ff <= '0;
         end
      end
   end

endmodule

@@ hw/rtl/chc_lut.sv @@
// ----------------------------------------------------------------------------
// chc_lut
// Stretch table memory; unwritten entries read as the identity mapping,
// which is the table for bounds 0 and 255.
// ----------------------------------------------------------------------------
module chc_lut import chc_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  lut_wr_type       wr,
   input  logic             rd_en,
   input  logic [BIN_W-1:0] rd_addr,
   output logic [BIN_W-1:0] rd_data
);

   logic [BIN_W-1:0]   mem [BIN_NUM];
   logic [BIN_NUM-1:0] valid_ff;
   logic [BIN_W-1:0]   rd_data_ff;
   logic [BIN_W-1:0]   rd_addr_ff;

   // Memory ports
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
         rd_addr_ff <= rd_addr;
      end
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
   end

   // Mark entries written since reset
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr.en) begin
         valid_ff[wr.addr] <= 1'b1;
      end
   end

   assign rd_data = valid_ff[rd_addr_ff] ? rd_data_ff : rd_addr_ff;

endmodule

@@ hw/rtl/histogram_clip_contrast_stretch.sv @@
// ----------------------------------------------------------------------------
// histogram_clip_contrast_stretch
// Two-pass 8-bit contrast stretch with percentile clipping.
// ----------------------------------------------------------------------------
// Count and map transactions are taken one per cycle while the sequencer is
// idle and no map result waits on a stalled output register; a map result is
// registered in the table read stage, then in the output register. A close
// transaction holds off the request channel while it runs: it forms the clip
// threshold (sample count divided by 1000 through a reciprocal multiply),
// scans the bin memory, settles the bounds, then builds the table, running
// the bit-serial divider once for each value not below the low bound, and
// finally gives the bounds result once the output register is free. A close
// on an empty histogram skips the threshold and the scan. After reset the
// table and histogram are ready at once; no clearing pass is needed.
module histogram_clip_contrast_stretch import chc_pkg::*; #(
   parameter longint unsigned MAX_SAMPLES = MAX_SAMPLES_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic [1:0]       req_action,
   input  logic [BIN_W-1:0] req_sample,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic             rsp_result_kind,
   output logic [BIN_W-1:0] rsp_mapped_value,
   output logic [BIN_W-1:0] rsp_low_bound,
   output logic [BIN_W-1:0] rsp_high_bound,
   input  logic             csr_wr_en,
   input  logic             csr_wr_data
);

   localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
   localparam int DIV_W = 2 * BIN_W;
   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_SAMPLES);
   localparam logic [BIN_W-1:0] BIN_LAST = BIN_W'(BIN_NUM - 1);

   // Clip threshold: total / 1000 = (total >> 3) / 125, and the division by
   // 125 is a multiply by ceil(2^36 / 125) and a shift, exact below 2^29
   localparam int                RECIP_PRE   = 3;
   localparam int                RECIP_SHIFT = 36;
   localparam int                PROD_W      = 59;
   localparam logic [PROD_W-1:0] RECIP_MULT  = PROD_W'(549755814);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LIMIT,
      ST_SCAN,
      ST_DECIDE,
      ST_BUILD,
      ST_QUOT,
      ST_EMIT
   } state_type;

   state_type        state_ff;
   logic             enable_ff;
   logic [CNT_W-1:0] total_ff;
   logic [BIN_W-1:0] lower_ff;
   logic [BIN_W-1:0] upper_ff;
   logic             map_valid_ff;
   logic [BIN_W-1:0] map_sample_ff;
   logic             out_valid_ff;
   logic             out_kind_ff;
   logic [BIN_W-1:0] out_value_ff;
   logic [BIN_W-1:0] out_low_ff;
   logic [BIN_W-1:0] out_high_ff;
   logic [CNT_W-1:0] limit_ff;
   logic [CNT_W-1:0] acc_ff;
   logic [BIN_W-1:0] scan_addr_ff;
   logic             scan_valid_ff;
   logic [BIN_W-1:0] scan_bin_ff;
   logic             lo_found_ff;
   logic [BIN_W-1:0] lo_ff;
   logic [BIN_W-1:0] hi_ff;
   logic [BIN_W-1:0] build_ff;

   logic              accept;
   logic              take_count;
   logic              take_close;
   logic              take_map;
   logic              map_move;
   logic              emit_load;
   logic              below_low;
   logic              scan_step;
   logic [CNT_W-1:0]  acc_sum;
   logic              lo_hit;
   logic              hi_hit;
   logic [PROD_W-1:0] limit_prod;
   logic              div_start;
   logic [DIV_W-1:0]  div_dividend;
   logic [DSR_W-1:0]  div_divisor;
   logic              div_done;
   logic [DIV_W-1:0]  div_quotient;
   logic [BIN_W-1:0]  quot_clamped;
   logic [CNT_W-1:0]  scan_data;
   logic [BIN_W-1:0]  lut_data;
   hist_ctl_type      hist_ctl;
   lut_wr_type        lut_wr;

   // Request handshake: only while idle, and a waiting map result moves on or the stage is free
   assign req_ready  = (state_ff == ST_IDLE) && (!map_valid_ff || !out_valid_ff || rsp_ready);
   assign accept     = req_valid && req_ready;
   assign take_count = accept && (req_action == ACT_COUNT) && (total_ff < CNT_MAX);
   assign take_close = accept && (req_action == ACT_CLOSE);
   assign take_map   = accept && (req_action == ACT_MAP);

   // Output register loads
   assign map_move  = map_valid_ff && (!out_valid_ff || rsp_ready);
   assign emit_load = (state_ff == ST_EMIT) && !map_valid_ff && (!out_valid_ff || rsp_ready);

   // Clip threshold from the sample count
   assign limit_prod = PROD_W'(total_ff >> RECIP_PRE) * RECIP_MULT;

   // Scan: prefix sum from the bottom gives low, remaining sum gives high
   assign scan_step = (state_ff == ST_SCAN) && scan_valid_ff;
   assign acc_sum   = acc_ff + scan_data;
   assign lo_hit    = !lo_found_ff && (acc_sum > limit_ff);
   assign hi_hit    = acc_ff < (total_ff - limit_ff);

   // Table build
   assign below_low    = build_ff < lower_ff;
   assign quot_clamped = (|div_quotient[DIV_W-1:BIN_W]) ? HIGH_DEFAULT
                                                        : div_quotient[BIN_W-1:0];

   // Divider: one table entry per run while building
   assign div_start    = (state_ff == ST_BUILD) && !below_low;
   assign div_dividend = DIV_W'({build_ff - lower_ff, 8'h00});
   assign div_divisor  = DSR_W'(upper_ff - lower_ff);

   // Histogram control
   assign hist_ctl.count_en  = take_count;
   assign hist_ctl.bin       = req_sample;
   assign hist_ctl.scan_en   = (state_ff == ST_SCAN);
   assign hist_ctl.scan_addr = scan_addr_ff;
   assign hist_ctl.clear     = (take_close && (total_ff == '0)) || (state_ff == ST_DECIDE);

   // Table writes
   assign lut_wr.en   = ((state_ff == ST_BUILD) && below_low)
                     || ((state_ff == ST_QUOT) && div_done);
   assign lut_wr.addr = build_ff;
   assign lut_wr.data = (state_ff == ST_QUOT) ? quot_clamped : '0;

   chc_divider #(
      .DIVIDEND_W (DIV_W)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quotient)
   );

   chc_hist #(
      .CNT_W (CNT_W)
   ) u_hist (
      .clock     (clock),
      .reset     (reset),
      .ctl       (hist_ctl),
      .scan_data (scan_data)
   );

   chc_lut u_lut (
      .clock   (clock),
      .reset   (reset),
      .wr      (lut_wr),
      .rd_en   (take_map),
      .rd_addr (req_sample),
      .rd_data (lut_data)
   );

   // Sequencer, bounds, count and handshake state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         enable_ff     <= 1'b1;
         total_ff      <= '0;
         lower_ff      <= LOW_DEFAULT;
         upper_ff      <= HIGH_DEFAULT;
         map_valid_ff  <= 1'b0;
         out_valid_ff  <= 1'b0;
         scan_valid_ff <= 1'b0;
         scan_addr_ff  <= '0;
         lo_found_ff   <= 1'b0;
         build_ff      <= '0;
      end else begin
         if (csr_wr_en) begin
            enable_ff <= csr_wr_data;
         end

         // Map stage and output register
         if (take_map) begin
            map_valid_ff <= 1'b1;
         end else if (map_move) begin
            map_valid_ff <= 1'b0;
         end
         if (map_move || emit_load) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end

         if (take_count) begin
            total_ff <= total_ff + 1'b1;
         end

         scan_valid_ff <= (state_ff == ST_SCAN);

         unique case (state_ff)
            ST_IDLE: begin
               if (take_close) begin
                  if (total_ff == '0) begin
                     lower_ff <= LOW_DEFAULT;
                     upper_ff <= HIGH_DEFAULT;
                     build_ff <= '0;
                     state_ff <= ST_BUILD;
                  end else begin
                     state_ff <= ST_LIMIT;
                  end
               end
            end
            ST_LIMIT: begin
               scan_addr_ff <= '0;
               lo_found_ff  <= 1'b0;
               state_ff     <= ST_SCAN;
            end
            ST_SCAN: begin
               scan_addr_ff <= scan_addr_ff + 1'b1;
               if (scan_step && lo_hit) begin
                  lo_found_ff <= 1'b1;
               end
               if (scan_step && (scan_bin_ff == BIN_LAST)) begin
                  state_ff <= ST_DECIDE;
               end
            end
            ST_DECIDE: begin
               // Crossed or equal bounds fall back to the full range
               if (lo_ff < hi_ff) begin
                  lower_ff <= lo_ff;
                  upper_ff <= hi_ff;
               end else begin
                  lower_ff <= LOW_DEFAULT;
                  upper_ff <= HIGH_DEFAULT;
               end
               total_ff <= '0;
               build_ff <= '0;
               state_ff <= ST_BUILD;
            end
            ST_BUILD: begin
               if (!below_low) begin
                  state_ff <= ST_QUOT;
               end else if (build_ff == BIN_LAST) begin
                  state_ff <= ST_EMIT;
               end else begin
                  build_ff <= build_ff + 1'b1;
               end
            end
            ST_QUOT: begin
               if (div_done) begin
                  if (build_ff == BIN_LAST) begin
                     state_ff <= ST_EMIT;
                  end else begin
                     build_ff <= build_ff + 1'b1;
                     state_ff <= ST_BUILD;
                  end
               end
            end
            ST_EMIT: begin
               if (emit_load) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (take_map) begin
         map_sample_ff <= req_sample;
      end

      if (map_move) begin
         out_kind_ff  <= KIND_MAP;
         out_value_ff <= enable_ff ? lut_data : map_sample_ff;
         out_low_ff   <= lower_ff;
         out_high_ff  <= upper_ff;
      end else if (emit_load) begin
         out_kind_ff  <= KIND_BOUNDS;
         out_value_ff <= '0;
         out_low_ff   <= lower_ff;
         out_high_ff  <= upper_ff;
      end

      // Scan accumulators
      scan_bin_ff <= scan_addr_ff;
      if (state_ff == ST_LIMIT) begin
         limit_ff <= CNT_W'(limit_prod[PROD_W-1:RECIP_SHIFT]);
         acc_ff   <= '0;
         lo_ff    <= LOW_DEFAULT;
         hi_ff    <= HIGH_DEFAULT;
      end else if (scan_step) begin
         acc_ff <= acc_sum;
         if (lo_hit) begin
            lo_ff <= scan_bin_ff;
         end
         if (hi_hit) begin
            hi_ff <= scan_bin_ff;
         end
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_result_kind  = out_kind_ff;
   assign rsp_mapped_value = out_value_ff;
   assign rsp_low_bound    = out_low_ff;
   assign rsp_high_bound   = out_high_ff;

endmodule

@@ hw/rtl/chc_checker.sv @@
// ----------------------------------------------------------------------------
// chc_checker
// Port-level checks for the histogram clip contrast stretch block.
// ----------------------------------------------------------------------------
module chc_checker import chc_pkg::*; (
   input logic             clock,
   input logic             reset,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input logic             rsp_result_kind,
   input logic [BIN_W-1:0] rsp_mapped_value,
   input logic [BIN_W-1:0] rsp_low_bound,
   input logic [BIN_W-1:0] rsp_high_bound
);

   // Hold a stalled response transaction
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_result_kind)
         && $stable(rsp_mapped_value) && $stable(rsp_low_bound)
         && $stable(rsp_high_bound))
      else $error("stalled response changed");

   // Drop any response after reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // Bounds results carry a zero mapped value
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_result_kind == KIND_BOUNDS) |-> (rsp_mapped_value == '0))
      else $error("bounds result with nonzero mapped value");

   // Bounds are ordered or the full range
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_low_bound < rsp_high_bound)
         || ((rsp_low_bound == LOW_DEFAULT) && (rsp_high_bound == HIGH_DEFAULT)))
      else $error("crossed clip bounds");

endmodule

bind histogram_clip_contrast_stretch chc_checker u_chc_checker (.*);
